// ===== rtl/core/skf_pkg.sv =====
// skf_pkg: shared widths, constants, codes and control types of the scalar kalman filter
// no dependencies; imported by every module under rtl/core
package skf_pkg;

    // field and register widths
    localparam int SAMPLE_W = 16;
    localparam int REG_W    = 20;
    localparam int GAIN_W   = 14;
    localparam int PRED_W   = REG_W + 1;
    localparam int DEN_W    = REG_W + 2;
    localparam int NUM_W    = PRED_W + GAIN_W;
    localparam int DPROD_W  = SAMPLE_W + GAIN_W;
    localparam int DVD_W    = NUM_W + 1;
    localparam int QUO_W    = PRED_W;
    localparam int DSH_W    = DEN_W + QUO_W - 1;
    localparam int STEP_W   = 5;
    localparam int IDX_W    = 2;

    // division by the gain scale (16 * 625): drop four bits, then multiply by
    // ceil(2^41 / 625), exact for every operand below 2^31
    localparam int SCL_SH  = 4;
    localparam int SCL_W   = NUM_W - SCL_SH;
    localparam int RCP_W   = 32;
    localparam int RCP_SH  = 41;
    localparam int RPROD_W = SCL_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_625 = 32'd3518437209;

    // gain scale and divider step count (gain quotient width)
    localparam logic [GAIN_W-1:0] GAIN_SCALE = GAIN_W'(10000);
    localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(GAIN_W);

    // register reset values
    localparam logic [REG_W-1:0] PN_RESET = REG_W'(1);
    localparam logic [REG_W-1:0] MN_RESET = REG_W'(10000);
    localparam logic [REG_W-1:0] IC_RESET = REG_W'(10000);
    localparam logic [REG_W-1:0] COV_MAX  = {REG_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] REG_PROCESS_NOISE      = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_INITIAL_COVARIANCE = IDX_W'(2);

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_GAIN,
        ST_MUL2,
        ST_SCALE,
        ST_UPDATE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul1;
        logic div_start;
        logic gain;
        logic mul2;
        logic scale;
        logic update;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/skf_div.sv =====
// skf_div: restoring divider, one quotient bit per cycle, run length set per start
// depends on skf_pkg
module skf_div
    import skf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    input  logic [STEP_W-1:0] steps,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    logic [DVD_W-1:0]  rem_reg,  rem_next;
    logic [DSH_W-1:0]  dsh_reg,  dsh_next;
    logic [QUO_W-1:0]  quo_reg,  quo_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              ge;

    // trial subtract of the shifted divisor
    assign ge = DSH_W'(rem_reg) >= dsh_reg;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = DSH_W'(divisor) << (steps - STEP_W'(1));
            quo_next  = '0;
            cnt_next  = steps;
            busy_next = (steps != '0);
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg[DVD_W-1:0];
            end
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - STEP_W'(1);
            busy_next = (cnt_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // a running division always has steps left
    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero step count");

    // a start with a nonzero run length makes the unit busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && steps != '0) |=> busy_reg)
        else $error("divider did not start");

endmodule

// ===== rtl/core/skf_datapath.sv =====
// skf_datapath: configuration registers, filter state, multipliers, gain divider, output register
// depends on skf_pkg and skf_div
module skf_datapath
    import skf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]    cfg_data,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    input  dp_cmd_t             cmd,
    output dp_status_t          status
);

    logic [REG_W-1:0]    pn_reg, mn_reg, ic_reg;
    logic [SAMPLE_W-1:0] est_reg;
    logic [REG_W-1:0]    cov_reg;
    logic [SAMPLE_W-1:0] meas_reg;
    logic [PRED_W-1:0]   pred_reg;
    logic [DEN_W-1:0]    denom_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [SAMPLE_W:0]   diff_reg;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [SAMPLE_W-1:0] mag_reg;
    logic                neg_reg;
    logic [DPROD_W-1:0]  dprod_reg;
    logic [NUM_W-1:0]    cprod_reg;
    logic [SAMPLE_W-1:0] dquo_reg;
    logic [PRED_W-1:0]   cquo_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [PRED_W-1:0]   pred_next;
    logic [SAMPLE_W:0]   mag_full;
    logic [SAMPLE_W:0]   delta_s;
    logic [SAMPLE_W:0]   est_sum;
    logic [REG_W-1:0]    cov_new;
    logic [SCL_W-1:0]    dscl, cscl;
    logic [RPROD_W-1:0]  drcp, crcp;

    logic                d0_busy;
    logic [QUO_W-1:0]    d0_quo;

    // gain division
    skf_div u_div0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (DVD_W'(num_reg)),
        .divisor  (denom_reg),
        .steps    (GAIN_STEPS),
        .busy     (d0_busy),
        .quotient (d0_quo)
    );

    // predicted covariance
    assign pred_next = PRED_W'(cov_reg) + PRED_W'(pn_reg);

    // gain, zero when the denominator is zero, capped at the scale
    always_comb begin
        if (denom_reg == '0) begin
            gain_next = '0;
        end else if (d0_quo > QUO_W'(GAIN_SCALE)) begin
            gain_next = GAIN_SCALE;
        end else begin
            gain_next = d0_quo[GAIN_W-1:0];
        end
    end

    // magnitude of the innovation
    assign mag_full = diff_reg[SAMPLE_W] ? (~diff_reg + (SAMPLE_W+1)'(1)) : diff_reg;

    // both products divided by the gain scale: drop four bits, multiply by 1/625
    assign dscl = SCL_W'(dprod_reg >> SCL_SH);
    assign cscl = cprod_reg[NUM_W-1:SCL_SH];
    assign drcp = RPROD_W'(dscl) * RPROD_W'(RCP_625);
    assign crcp = RPROD_W'(cscl) * RPROD_W'(RCP_625);

    // signed estimate step and new estimate
    assign delta_s = neg_reg ? (~{1'b0, dquo_reg} + (SAMPLE_W+1)'(1))
                             : {1'b0, dquo_reg};
    assign est_sum = {est_reg[SAMPLE_W-1], est_reg} + delta_s;

    // new covariance with saturation
    assign cov_new = cquo_reg[PRED_W-1] ? COV_MAX : cquo_reg[REG_W-1:0];

    // sequenced datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            meas_reg  <= s_tdata;
            pred_reg  <= pred_next;
            denom_reg <= DEN_W'(pred_next) + DEN_W'(mn_reg);
        end
        if (cmd.mul1) begin
            num_reg  <= NUM_W'(pred_reg) * NUM_W'(GAIN_SCALE);
            diff_reg <= {meas_reg[SAMPLE_W-1], meas_reg} - {est_reg[SAMPLE_W-1], est_reg};
        end
        if (cmd.gain) begin
            mag_reg <= mag_full[SAMPLE_W-1:0];
            neg_reg <= diff_reg[SAMPLE_W];
        end
        if (cmd.mul2) begin
            dprod_reg <= DPROD_W'(mag_reg) * DPROD_W'(gain_reg);
            cprod_reg <= NUM_W'(GAIN_SCALE - gain_reg) * NUM_W'(pred_reg);
        end
        if (cmd.scale) begin
            dquo_reg <= drcp[RCP_SH+SAMPLE_W-1:RCP_SH];
            cquo_reg <= crcp[RCP_SH+PRED_W-1:RCP_SH];
        end
        if (cmd.update) begin
            out_data_reg <= est_sum[SAMPLE_W-1:0];
        end
    end

    // state, configuration and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg        <= PN_RESET;
            mn_reg        <= MN_RESET;
            ic_reg        <= IC_RESET;
            est_reg       <= '0;
            cov_reg       <= IC_RESET;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.gain) begin
                gain_reg <= gain_next;
            end
            if (cmd.update) begin
                est_reg       <= est_sum[SAMPLE_W-1:0];
                cov_reg       <= cov_new;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE:     pn_reg <= cfg_data;
                    REG_MEASUREMENT_NOISE: mn_reg <= cfg_data;
                    REG_INITIAL_COVARIANCE: begin
                        ic_reg  <= cfg_data;
                        cov_reg <= cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.div_busy = d0_busy;
    assign status.out_free = !out_valid_reg || m_tready;

    // the gain never exceeds the scale
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= GAIN_SCALE)
        else $error("gain above scale");

endmodule

// ===== rtl/core/skf_ctrl.sv =====
// skf_ctrl: sequencer for one filter step, drives the datapath commands
// depends on skf_pkg
module skf_ctrl
    import skf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no new sample is taken while a division runs
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.div_busy)
        else $error("input ready while divider busy");

    // a result is only written into a free output register
    a_update_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> status.out_free)
        else $error("result written over pending output");

endmodule

// ===== rtl/core/scalar_kalman_filter.sv =====
// scalar_kalman_filter: top level of the one-dimensional fixed-point kalman filter
// depends on skf_pkg, skf_ctrl, skf_datapath (which holds one skf_div unit)
//
// usage:
//   s_* channel takes one signed 16-bit measurement per transaction; m_* channel
//   returns one signed 16-bit updated estimate per measurement, in order.
//   cfg_* channel writes the noise and initial covariance registers; cfg_ready is
//   always high. write only while no sample is in flight. writing the initial
//   covariance also reloads the running covariance. unknown indexes are ignored.
// processing:
//   from acceptance to m_tvalid the sample passes the first products, divider
//   start, the gain division (14 steps of a restoring divider), divider done,
//   gain, second products, scaling and output write.
//   one sample at a time; the next is accepted in the cycle after the result is
//   written to the output register.
// reset:
//   aresetn low clears the estimate to zero, loads register reset values and sets
//   the covariance to the initial covariance reset value.
// stall:
//   a result waits in the output register; the next sample may be accepted
//   meanwhile, but its result is held back until the previous one is taken.
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]    cfg_data,
    // measurement input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] measurement
    // estimate output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata    // [15:0] estimate
);

    dp_cmd_t    cmd;
    dp_status_t status;

    skf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for scalar_kalman_filter, stream-in measurements, stream-out estimates
// depends on skf_pkg and the scalar_kalman_filter rtl; predicts each estimate in fixed point
// and compares every output transaction in order, across several noise settings and idle patterns
module tb
    import skf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, writes to it must be ignored
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS = 160;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [REG_W-1:0]    cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;

    // samples waiting to be sent, estimates waiting to come back
    logic [SAMPLE_W-1:0] measurement_q[$];
    logic [SAMPLE_W-1:0] estimate_q[$];
    logic [SAMPLE_W-1:0] want_estimate;

    int    sender_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    mismatches = 0;
    int    cycle_count = 0;
    bit    s_taken = 1'b0;
    longint track_target = 0;

    // filter state as the block should hold it
    longint noise_proc;
    longint noise_meas;
    longint cov_init;
    longint est_state;
    longint cov_state;

    scalar_kalman_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock, 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // one filter step: predicted covariance, gain, estimate and covariance update
    function automatic logic [SAMPLE_W-1:0] kalman_update(input logic signed [SAMPLE_W-1:0] meas);
        longint scale;
        longint pred;
        longint denom;
        longint gain;
        longint diff;
        longint delta;
        longint cov;
        scale = longint'(GAIN_SCALE);
        pred  = cov_state + noise_proc;
        denom = pred + noise_meas;
        gain  = 0;
        if (denom != 0) begin
            gain = (pred * scale) / denom;
        end
        if (gain > scale) begin
            gain = scale;
        end
        diff = longint'(meas) - est_state;
        delta = (diff * gain) / scale;
        est_state = est_state + delta;
        cov = ((scale - gain) * pred) / scale;
        if (cov > longint'(COV_MAX)) begin
            cov = longint'(COV_MAX);
        end
        cov_state = cov;
        return est_state[SAMPLE_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        case (idx)
            REG_PROCESS_NOISE: begin
                noise_proc = longint'(val);
            end
            REG_MEASUREMENT_NOISE: begin
                noise_meas = longint'(val);
            end
            REG_INITIAL_COVARIANCE: begin
                // also reloads the running covariance, estimate untouched
                cov_init  = longint'(val);
                cov_state = longint'(val);
            end
            default: begin
            end
        endcase
    endfunction

    // register value: mostly in range, some at the extremes of the field
    function automatic logic [REG_W-1:0] rand_reg();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COV_MAX;
            2: return REG_W'(1000000);
            3, 4, 5: return REG_W'($urandom_range(0, 1000));
            default: return REG_W'($urandom_range(0, 1000000));
        endcase
    endfunction

    // sample: mostly a noisy signal around a slowly jumping level, plus extremes and noise
    function automatic logic [SAMPLE_W-1:0] gen_sample();
        longint v;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return SAMPLE_W'($urandom);
            default: begin
                if ($urandom_range(0, 15) == 0) begin
                    track_target = longint'($signed(SAMPLE_W'($urandom)));
                end
                v = track_target + longint'($urandom_range(0, 400)) - 200;
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                return v[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    // monitor: config writes, accepted samples and returned estimates
    always @(posedge aclk) begin
        if (!aresetn) begin
            noise_proc = longint'(PN_RESET);
            noise_meas = longint'(MN_RESET);
            cov_init   = longint'(IC_RESET);
            est_state  = 0;
            cov_state  = cov_init;
            s_taken    = 1'b0;
            estimate_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                estimate_q.push_back(kalman_update(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (estimate_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 20) begin
                        $display("%0t: unexpected estimate, expected none, got %0d",
                                 $time, $signed(m_tdata));
                    end
                end else begin
                    want_estimate = estimate_q.pop_front();
                    if (m_tdata !== want_estimate) begin
                        mismatches++;
                        if (mismatches <= 20) begin
                            $display("%0t: estimate mismatch, expected %0d, got %0d",
                                     $time, $signed(want_estimate), $signed(m_tdata));
                        end
                    end
                end
            end
        end
    end

    // driver: sample transactions with random gaps, random output stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_taken) begin
                if (measurement_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= measurement_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // block idle: nothing queued, nothing in flight
    task automatic wait_drained();
        do @(negedge aclk);
        while (measurement_q.size() != 0 || s_tvalid || estimate_q.size() != 0);
    endtask

    // one random phase, with a full pause halfway through
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int i;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        write_reg(REG_PROCESS_NOISE, rand_reg());
        write_reg(REG_MEASUREMENT_NOISE, rand_reg());
        write_reg(REG_INITIAL_COVARIANCE, rand_reg());
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_UNUSED, REG_W'($urandom));
        end
        end_writes();
        for (i = 0; i < count / 2; i++) begin
            measurement_q.push_back(gen_sample());
        end
        wait_drained();
        for (i = count / 2; i < count; i++) begin
            measurement_q.push_back(gen_sample());
        end
        wait_drained();
    endtask

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // sequence: reset, directed cases, random phases, final check
    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, sample extremes and alternating bit patterns
        measurement_q.push_back(16'h7fff);
        measurement_q.push_back(16'h8000);
        measurement_q.push_back(16'h0000);
        measurement_q.push_back(16'hffff);
        measurement_q.push_back(16'h5555);
        measurement_q.push_back(16'haaaa);
        wait_drained();

        // zero denominator: gain zero, estimate and covariance held
        write_reg(REG_UNUSED, COV_MAX);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_INITIAL_COVARIANCE, '0);
        end_writes();
        measurement_q.push_back(SAMPLE_W'(1000));
        measurement_q.push_back(SAMPLE_W'(-1000));
        wait_drained();

        // zero measurement noise with covariance present: estimate jumps to the first sample, then holds
        write_reg(REG_INITIAL_COVARIANCE, REG_W'(500));
        end_writes();
        measurement_q.push_back(16'h8000);
        measurement_q.push_back(16'h7fff);
        measurement_q.push_back(SAMPLE_W'(5));
        wait_drained();

        // all noise and covariance registers at the field maximum
        write_reg(REG_PROCESS_NOISE, COV_MAX);
        write_reg(REG_MEASUREMENT_NOISE, COV_MAX);
        write_reg(REG_INITIAL_COVARIANCE, COV_MAX);
        end_writes();
        measurement_q.push_back(16'h7fff);
        measurement_q.push_back(16'h8000);
        measurement_q.push_back(SAMPLE_W'(100));
        wait_drained();

        // in-range extremes: near-unity gain
        write_reg(REG_PROCESS_NOISE, REG_W'(1000000));
        write_reg(REG_MEASUREMENT_NOISE, REG_W'(1));
        write_reg(REG_INITIAL_COVARIANCE, REG_W'(1000000));
        end_writes();
        measurement_q.push_back(16'h8000);
        measurement_q.push_back(16'h7fff);
        measurement_q.push_back(SAMPLE_W'(-3));
        measurement_q.push_back(SAMPLE_W'(12345));
        wait_drained();

        // heavy smoothing: gain near zero
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, REG_W'(1000000));
        write_reg(REG_INITIAL_COVARIANCE, '0);
        end_writes();
        measurement_q.push_back(16'h7fff);
        measurement_q.push_back(16'h8000);
        measurement_q.push_back(16'h7fff);
        wait_drained();

        // random phases: no idling, sender gaps, receiver stalls, both
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(62, 0, PHASE_ITEMS);
        run_phase(0, 62, PHASE_ITEMS);
        run_phase(18, 18, PHASE_ITEMS);

        // catch late or extra transactions
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (estimate_q.size() != 0) begin
            mismatches++;
            $display("%0t: %0d estimates never arrived, expected %0d, got none",
                     $time, estimate_q.size(), $signed(estimate_q[0]));
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
